### rtl/hds_pkg.sv
// Shared constants and types for the heat diffusion stencil block.
package hds_pkg;

   // Default sizes, handed to the top level parameters.
   localparam int MAX_POINTS_DEF = 1024;
   localparam int TEMP_BITS_DEF  = 32;
   localparam int STEP_CELLS_DEF = 4;

   // Fixed field widths of the transactions and registers.
   localparam int OPCODE_BITS    = 2;
   localparam int INDEX_BITS     = 10;
   localparam int VALUE_BITS     = 32;
   localparam int STEPS_BITS     = 16;
   localparam int FACTOR_BITS    = 16;
   localparam int POINTS_BITS    = 11;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   // Q0.16 factor: fraction bits dropped after the product.
   localparam int FRAC_BITS = 16;

   localparam logic [FACTOR_BITS-1:0] FACTOR_LIMIT = 16'd32768;
   localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 16'd16384;
   localparam logic [POINTS_BITS-1:0] POINTS_RESET = 11'd1000;
   localparam int                     MIN_POINTS   = 3;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_WRITE = 2'd0,
      OP_STEP  = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FACTOR = 1'b0,
      CSR_POINTS = 1'b1
   } csr_index_type;

endpackage

### rtl/hds_req_if.sv
// Request channel: opcode, point index, point value and step count.
interface hds_req_if;
   import hds_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [OPCODE_BITS-1:0]       opcode;
   logic [INDEX_BITS-1:0]        point_index;
   logic signed [VALUE_BITS-1:0] point_value;
   logic [STEPS_BITS-1:0]        step_count;

   modport source (output valid, opcode, point_index, point_value, step_count,
                   input ready);
   modport sink   (input valid, opcode, point_index, point_value, step_count,
                   output ready);
endinterface

### rtl/hds_rsp_if.sv
// Response channel: read value and bad index flag.
interface hds_rsp_if;
   import hds_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] read_value;
   logic                         index_bad;

   modport source (output valid, read_value, index_bad, input ready);
   modport sink   (input valid, read_value, index_bad, output ready);
endinterface

### rtl/hds_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module hds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/hds_cell.sv
// One time-step cell: windows the point stream and emits updated points.
module hds_cell #(
   parameter int TEMP_BITS = hds_pkg::TEMP_BITS_DEF,
   parameter int IW        = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              active,
   input  logic [IW-1:0]                     last_index,
   input  logic [hds_pkg::FACTOR_BITS-1:0]   factor,
   input  logic                              in_valid,
   input  logic [IW-1:0]                     in_index,
   input  logic signed [TEMP_BITS-1:0]       in_value,
   output logic                              out_valid,
   output logic [IW-1:0]                     out_index,
   output logic signed [TEMP_BITS-1:0]       out_value
);
   import hds_pkg::*;

   localparam int LW = TEMP_BITS + 2;
   localparam int PW = LW + FACTOR_BITS + 1;
   localparam logic signed [PW-1:0] SAT_MAX =
      {{(PW-TEMP_BITS+1){1'b0}}, {(TEMP_BITS-1){1'b1}}};
   localparam logic signed [PW-1:0] SAT_MIN = ~SAT_MAX;

   // window: p1 is the previous point, p2 the one before it
   logic signed [TEMP_BITS-1:0] p2_ff, p1_ff;

   logic                        s1_valid_ff, s1_valid_in;
   logic [IW-1:0]               s1_index_ff, s1_index_in;
   logic signed [TEMP_BITS-1:0] s1_self_ff;
   logic signed [LW-1:0]        s1_lap_ff, s1_lap_in;
   logic                        s1_edge_ff, s1_edge_in;

   logic signed [FACTOR_BITS:0] factor_s;
   logic signed [PW-1:0]        prod, delta, sum;
   logic signed [TEMP_BITS-1:0] sat_value;

   logic                        out_valid_ff;
   logic [IW-1:0]               out_index_ff;
   logic signed [TEMP_BITS-1:0] out_value_ff, out_value_in;

   // stage 1: laplacian of the point before the incoming one
   always_comb begin
      s1_valid_in = in_valid && (in_index != '0);
      s1_index_in = in_index - IW'(1);
      s1_lap_in   = LW'(p2_ff) - (LW'(p1_ff) <<< 1) + LW'(in_value);
      s1_edge_in  = (s1_index_in == '0) || (s1_index_in == last_index);
   end

   // stage 2: scale, floor, add, saturate; edges zero, inactive cell passes
   always_comb begin
      factor_s = $signed({1'b0, factor});
      prod     = s1_lap_ff * factor_s;
      delta    = prod >>> FRAC_BITS;
      sum      = PW'(s1_self_ff) + delta;
      if (sum > SAT_MAX) begin
         sat_value = TEMP_BITS'(SAT_MAX);
      end else if (sum < SAT_MIN) begin
         sat_value = TEMP_BITS'(SAT_MIN);
      end else begin
         sat_value = sum[TEMP_BITS-1:0];
      end
      if (!active) begin
         out_value_in = s1_self_ff;
      end else if (s1_edge_ff) begin
         out_value_in = '0;
      end else begin
         out_value_in = sat_value;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         p2_ff <= p1_ff;
         p1_ff <= in_value;
      end
      s1_index_ff  <= s1_index_in;
      s1_self_ff   <= p1_ff;
      s1_lap_ff    <= s1_lap_in;
      s1_edge_ff   <= s1_edge_in;
      out_index_ff <= s1_index_ff;
      out_value_ff <= out_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= s1_valid_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_index = out_index_ff;
   assign out_value = out_value_ff;
endmodule

### rtl/heat_diffusion_1d_stencil.sv
// Top level of the 1-D explicit heat diffusion stencil.
//
// Usage:
//  - req_ch carries one transaction per item: write a point, read a point, or
//    run step_count explicit time steps over points 0 .. n-1. rsp_ch returns
//    exactly one transaction per item (read value, bad index flag).
//  - csr_we/csr_index/csr_wdata set the diffusion factor and the point count;
//    write them only while the block is idle.
//  - A write answers from the response register; a read first passes ST_READ.
//    A run of S steps makes ceil(S/STEP_CELLS) passes over the bar: the RAM
//    is streamed through a chain of STEP_CELLS cells, each cell doing one
//    time step, and every pass waits for the last write-back before the
//    next one reads.
//  - One item at a time; a new request is taken while the previous response
//    is being taken in the same cycle.
//  - Reset: a sweep writes zeros to all MAX_POINTS entries of the bar;
//    req_ch.ready stays low during it. Configuration writes are taken always.
//  - A stalled rsp_ch holds its response and blocks further requests.
module heat_diffusion_1d_stencil #(
   parameter int MAX_POINTS = hds_pkg::MAX_POINTS_DEF,
   parameter int TEMP_BITS  = hds_pkg::TEMP_BITS_DEF,
   parameter int STEP_CELLS = hds_pkg::STEP_CELLS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   hds_req_if.sink                             req_ch,
   hds_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [hds_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [hds_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import hds_pkg::*;

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int IW   = $clog2(MAX_POINTS + STEP_CELLS + 1);
   localparam int CW_A = (INDEX_BITS > POINTS_BITS) ? INDEX_BITS : POINTS_BITS;
   localparam int CW   = (CW_A > IW) ? CW_A : IW;
   localparam int WW   = (TEMP_BITS > VALUE_BITS) ? TEMP_BITS : VALUE_BITS;
   localparam logic signed [WW-1:0] WR_MAX =
      {{(WW-TEMP_BITS+1){1'b0}}, {(TEMP_BITS-1){1'b1}}};
   localparam logic signed [WW-1:0] WR_MIN = ~WR_MAX;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_PASS  = 5'b01000,
      ST_DRAIN = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic [AW-1:0]                clr_cnt_ff, clr_cnt_in;
   logic [CW-1:0]                rd_cnt_ff, rd_cnt_in;
   logic [STEPS_BITS-1:0]        steps_ff, steps_in;
   logic                         tok_valid_ff;
   logic [IW-1:0]                tok_index_ff;

   logic [FACTOR_BITS-1:0]       factor_ff, factor_eff;
   logic [POINTS_BITS-1:0]       points_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]        rsp_value_ff, rsp_value_in;
   logic                         rsp_bad_ff, rsp_bad_in;

   logic                         ram_we;
   logic [AW-1:0]                ram_waddr, ram_raddr;
   logic [TEMP_BITS-1:0]         ram_wdata, ram_rdata;

   logic                         req_accept;
   opcode_type                   req_op;
   logic [CW-1:0]                pts_cw, n_cw, last_cw, idx_cw;
   logic                         idx_ok;
   logic signed [WW-1:0]         wr_wide, rd_wide;
   logic [TEMP_BITS-1:0]         wr_sat;

   // cell chain taps: entry 0 is the RAM stream, entry STEP_CELLS the result
   logic                         c_valid [STEP_CELLS+1];
   logic [IW-1:0]                c_index [STEP_CELLS+1];
   logic signed [TEMP_BITS-1:0]  c_value [STEP_CELLS+1];
   logic                         fin_valid;
   logic [IW-1:0]                fin_index;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_RESET;
         points_ff <= POINTS_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FACTOR: factor_ff <= csr_wdata[FACTOR_BITS-1:0];
            CSR_POINTS: points_ff <= csr_wdata[POINTS_BITS-1:0];
            default:    ;
         endcase
      end
   end

   // factor above one half acts as one half
   assign factor_eff = (factor_ff > FACTOR_LIMIT) ? FACTOR_LIMIT : factor_ff;

   // active point count n, limited to MIN_POINTS .. MAX_POINTS
   always_comb begin
      pts_cw = CW'(points_ff);
      if (pts_cw < CW'(MIN_POINTS)) begin
         n_cw = CW'(MIN_POINTS);
      end else if (pts_cw > CW'(MAX_POINTS)) begin
         n_cw = CW'(MAX_POINTS);
      end else begin
         n_cw = pts_cw;
      end
      last_cw = n_cw - CW'(1);
   end

   // ---------------------------------------------------------------------
   // request decode and value conversion
   // ---------------------------------------------------------------------
   assign req_ch.ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_accept    = req_ch.valid && req_ch.ready;
   assign req_op        = opcode_type'(req_ch.opcode);
   assign idx_cw        = CW'(req_ch.point_index);
   assign idx_ok        = idx_cw < n_cw;

   // written value saturated into the stored width
   always_comb begin
      wr_wide = WW'(req_ch.point_value);
      if (wr_wide > WR_MAX) begin
         wr_sat = TEMP_BITS'(WR_MAX);
      end else if (wr_wide < WR_MIN) begin
         wr_sat = TEMP_BITS'(WR_MIN);
      end else begin
         wr_sat = wr_wide[TEMP_BITS-1:0];
      end
   end

   // stored value to the 32-bit response field
   assign rd_wide = WW'($signed(ram_rdata));

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      rd_cnt_in    = rd_cnt_ff;
      steps_in     = steps_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_bad_in   = rsp_bad_ff;
      // write-back from the last cell during a pass
      ram_we       = fin_valid;
      ram_waddr    = fin_index[AW-1:0];
      ram_wdata    = c_value[STEP_CELLS];
      ram_raddr    = rd_cnt_ff[AW-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(MAX_POINTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ram_raddr = idx_cw[AW-1:0];
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_bad_in   = 1'b0;
               unique case (req_op)
                  OP_WRITE: begin
                     if (idx_ok) begin
                        ram_we    = 1'b1;
                        ram_waddr = idx_cw[AW-1:0];
                        ram_wdata = wr_sat;
                     end else begin
                        rsp_bad_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (idx_ok) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_READ;
                     end else begin
                        rsp_bad_in = 1'b1;
                     end
                  end
                  OP_STEP: begin
                     if (req_ch.step_count != '0) begin
                        rsp_valid_in = 1'b0;
                        steps_in     = req_ch.step_count;
                        rd_cnt_in    = '0;
                        state_in     = ST_PASS;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_wide[VALUE_BITS-1:0];
            rsp_bad_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_PASS: begin
            // stream points 0 .. n-1 and one flush transaction per cell
            rd_cnt_in = rd_cnt_ff + CW'(1);
            if (rd_cnt_ff == last_cw + CW'(STEP_CELLS)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last point written back: the pass is complete
            if (fin_valid && (CW'(fin_index) == last_cw)) begin
               if (steps_ff <= STEPS_BITS'(STEP_CELLS)) begin
                  steps_in     = '0;
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  rsp_bad_in   = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  steps_in  = steps_ff - STEPS_BITS'(STEP_CELLS);
                  rd_cnt_in = '0;
                  state_in  = ST_PASS;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rd_cnt_ff    <= '0;
         steps_ff     <= '0;
         tok_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rd_cnt_ff    <= rd_cnt_in;
         steps_ff     <= steps_in;
         tok_valid_ff <= (state_ff == ST_PASS);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tok_index_ff <= IW'(rd_cnt_ff);
      rsp_value_ff <= rsp_value_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_value_ff;
   assign rsp_ch.index_bad  = rsp_bad_ff;

   // ---------------------------------------------------------------------
   // bar storage
   // ---------------------------------------------------------------------
   hds_ram #(
      .WIDTH (TEMP_BITS),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------------
   // chain of time-step cells; cell k runs only while more than k steps remain
   // ---------------------------------------------------------------------
   assign c_valid[0] = tok_valid_ff;
   assign c_index[0] = tok_index_ff;
   assign c_value[0] = ram_rdata;

   for (genvar k = 0; k < STEP_CELLS; k++) begin : g_cell
      hds_cell #(
         .TEMP_BITS (TEMP_BITS),
         .IW        (IW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .active     (steps_ff > STEPS_BITS'(k)),
         .last_index (IW'(last_cw)),
         .factor     (factor_eff),
         .in_valid   (c_valid[k]),
         .in_index   (c_index[k]),
         .in_value   (c_value[k]),
         .out_valid  (c_valid[k+1]),
         .out_index  (c_index[k+1]),
         .out_value  (c_value[k+1])
      );
   end

   assign fin_valid = c_valid[STEP_CELLS];
   assign fin_index = c_index[STEP_CELLS];

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // the chain never writes back beyond the active bar
   a_fin_in_range: assert property (@(posedge clock) disable iff (reset)
      fin_valid |-> (CW'(fin_index) <= last_cw))
      else $error("write-back index beyond active points");

   // write-back only happens while a run of steps is in progress
   a_fin_in_pass: assert property (@(posedge clock) disable iff (reset)
      fin_valid |-> ((state_ff == ST_PASS) || (state_ff == ST_DRAIN)))
      else $error("cell chain output outside a pass");

   // a good read answers from the response register after passing ST_READ
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_READ) && idx_ok) |=> ##1 rsp_valid_ff)
      else $error("read response missing");

   // a held response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> (rsp_valid_ff && $stable(rsp_value_ff)))
      else $error("stalled response changed");
endmodule
